/* rtl/hrlc_pkg.sv */
// hrlc_pkg: shared types, constants and the extension lookup for the
// request line checker. No dependencies; used by every rtl module but hrlc_checker.
`default_nettype none

package hrlc_pkg;

    // directory depth counter width
    localparam int DEPTH_BITS = 8;

    // result queue
    localparam int FIFO_AW     = 3;
    localparam int FIFO_DEPTH  = 1 << FIFO_AW;
    localparam int CNT_W       = FIFO_AW + 1;
    // a request may only enter while two more results are guaranteed to fit
    localparam int READY_LIMIT = FIFO_DEPTH - 2;

    // characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'd37;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_D     = 8'h44;

    // result kinds
    localparam logic KIND_PATH    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // verdict codes
    localparam logic [1:0] VER_OK        = 2'd0;
    localparam logic [1:0] VER_BAD_REQ   = 2'd1;
    localparam logic [1:0] VER_FORBIDDEN = 2'd2;

    // method classes
    localparam logic [1:0] MC_GET   = 2'd0;
    localparam logic [1:0] MC_HEAD  = 2'd1;
    localparam logic [1:0] MC_OTHER = 2'd2;

    // content types
    localparam logic [3:0] CT_HTML    = 4'd0;
    localparam logic [3:0] CT_CSS     = 4'd1;
    localparam logic [3:0] CT_JS      = 4'd2;
    localparam logic [3:0] CT_JPG     = 4'd3;
    localparam logic [3:0] CT_JPEG    = 4'd4;
    localparam logic [3:0] CT_PNG     = 4'd5;
    localparam logic [3:0] CT_GIF     = 4'd6;
    localparam logic [3:0] CT_SWF     = 4'd7;
    localparam logic [3:0] CT_UNKNOWN = 4'd8;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] path_byte;
        logic [1:0] verdict;
        logic [1:0] method_class;
        logic [3:0] content_type;
        logic       is_index;
        logic       last;
    } item_t;

    // results of one request, in delivery order: path byte then verdict
    typedef struct packed {
        logic  path_valid;
        item_t path_item;
        logic  verdict_valid;
        item_t verdict_item;
    } push_t;

    localparam logic [31:0] EXT_CODE [8] = '{
        32'h68746D6C, 32'h00637373, 32'h00006A73, 32'h006A7067,
        32'h6A706567, 32'h00706E67, 32'h00676966, 32'h00737766
    };
    localparam logic [2:0] EXT_LEN [8] = '{
        3'd4, 3'd3, 3'd2, 3'd3, 3'd4, 3'd3, 3'd3, 3'd3
    };

    // n_chars: characters after the dot (0..4), chars: right aligned
    function automatic logic [3:0] ext_type(input logic [2:0] n_chars,
                                            input logic [31:0] chars);
        logic [3:0] ct;
        ct = CT_UNKNOWN;
        for (int i = 7; i >= 0; i--) begin
            if (EXT_LEN[i] == n_chars && EXT_CODE[i] == chars) begin
                ct = 4'(i);
            end
        end
        return ct;
    endfunction

endpackage

`default_nettype wire

/* rtl/http_request_line_checker_top.sv */
// http_request_line_checker_top: request line parser with percent decoding.
// Depends on hrlc_pkg, hrlc_parser and hrlc_out_fifo.
//
//   channel  dir  handshake          payload
//   s_       in   s_tvalid/s_tready  s_tdata[7:0] request_byte, s_tlast line_end
//   m_       out  m_tvalid/m_tready  m_tdata path_byte..is_index, m_tuser item_kind,
//                                    m_tlast last
//
// one request byte is taken per cycle while s_tready is high; a result passes
// through the input register, then the result queue
// the last byte of a line gives up to two results, drained one per cycle while m_tready is high
// s_tready drops while the 8-entry result queue cannot take two more results
// aresetn (synchronous, active low) empties the queue and clears line state
`default_nettype none

module http_request_line_checker_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] request_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] path_byte, [9:8] verdict,
                                        // [11:10] method_class, [15:12] content_type,
                                        // [16] is_index, [23:17] zero
    output logic [0:0]       m_tuser,   // [0] item_kind
    output logic             m_tlast
);
    import hrlc_pkg::*;

    logic             busy;
    push_t            push;
    item_t            item;
    logic [CNT_W-1:0] count;
    logic [CNT_W:0]   fill;
    logic             s_accept;

    assign fill     = {1'b0, count} + (busy ? (CNT_W+1)'(2) : '0);
    assign s_tready = fill <= (CNT_W+1)'(READY_LIMIT);
    assign s_accept = s_tvalid && s_tready;

    hrlc_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (s_accept),
        .in_byte     (s_tdata),
        .in_line_end (s_tlast),
        .busy        (busy),
        .push        (push)
    );

    hrlc_out_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_item  (item),
        .count     (count)
    );

    assign m_tdata = {7'd0, item.is_index, item.content_type, item.method_class,
                      item.verdict, item.path_byte};
    assign m_tuser = item.item_kind;
    assign m_tlast = item.last;

endmodule

`default_nettype wire

/* rtl/hrlc_parser.sv */
// hrlc_parser: input register and line state; turns one request byte into
// at most one path byte result and one verdict result. Depends on hrlc_pkg.
`default_nettype none

module hrlc_parser (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_accept,
    input  wire logic [7:0]     in_byte,
    input  wire logic           in_line_end,
    output logic                busy,
    output hrlc_pkg::push_t     push
);
    import hrlc_pkg::*;

    typedef enum logic [1:0] {
        SEC_METHOD, SEC_PATH, SEC_QUERY, SEC_TAIL
    } section_t;

    typedef enum logic [2:0] {
        M_START, M_G, M_GE, M_GET, M_H, M_HE, M_HEA, M_HEAD
    } method_t;

    typedef enum logic [1:0] {
        DEC_PLAIN, DEC_HEX, DEC_BAD
    } decode_t;

    typedef enum logic [1:0] {
        DD_NONE, DD_SLASH, DD_DOT
    } dotdot_t;

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_end_reg;

    section_t              section_reg,   section_next;
    method_t               method_reg,    method_next;
    logic                  mfail_reg,     mfail_next;
    logic                  extra_reg,     extra_next;
    decode_t               dphase_reg,    dphase_next;
    logic [7:0]            hex_reg,       hex_next;
    logic [1:0]            hcnt_reg,      hcnt_next;
    dotdot_t               dotdot_reg,    dotdot_next;
    logic [DEPTH_BITS-1:0] depth_reg,     depth_next;
    logic                  forbid_reg,    forbid_next;
    logic [31:0]           ext_reg,       ext_next;
    logic [2:0]            elen_reg,      elen_next;
    logic [7:0]            lastc_reg,     lastc_next;
    logic                  empty_reg,     empty_next;

    function automatic logic [4:0] hex_of(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    logic       emit;
    logic [7:0] emit_c;
    logic [4:0] hd;
    logic       is_idx;
    logic [3:0] ctype;
    logic [1:0] mclass;
    logic [1:0] ver;
    method_t    mstep;

    always_comb begin
        section_next = section_reg;
        method_next  = method_reg;
        mfail_next   = mfail_reg;
        extra_next   = extra_reg;
        dphase_next  = dphase_reg;
        hex_next     = hex_reg;
        hcnt_next    = hcnt_reg;
        dotdot_next  = dotdot_reg;
        depth_next   = depth_reg;
        forbid_next  = forbid_reg;
        ext_next     = ext_reg;
        elen_next    = elen_reg;
        lastc_next   = lastc_reg;
        empty_next   = empty_reg;
        emit         = 1'b0;
        emit_c       = 8'd0;
        hd           = hex_of(in_byte_reg);
        mstep        = M_START;

        unique case (section_reg)
            SEC_METHOD: begin
                if (in_byte_reg == CH_SPACE) begin
                    section_next = SEC_PATH;
                end else if (!mfail_reg) begin
                    mfail_next = 1'b1;
                    unique case (method_reg)
                        M_START: begin
                            if (in_byte_reg == CH_G) begin
                                mstep = M_G; mfail_next = 1'b0;
                            end else if (in_byte_reg == CH_H) begin
                                mstep = M_H; mfail_next = 1'b0;
                            end
                        end
                        M_G:   if (in_byte_reg == CH_E) begin mstep = M_GE;   mfail_next = 1'b0; end
                        M_GE:  if (in_byte_reg == CH_T) begin mstep = M_GET;  mfail_next = 1'b0; end
                        M_H:   if (in_byte_reg == CH_E) begin mstep = M_HE;   mfail_next = 1'b0; end
                        M_HE:  if (in_byte_reg == CH_A) begin mstep = M_HEA;  mfail_next = 1'b0; end
                        M_HEA: if (in_byte_reg == CH_D) begin mstep = M_HEAD; mfail_next = 1'b0; end
                        default: ;
                    endcase
                    if (!mfail_next) begin
                        method_next = mstep;
                    end
                end
            end
            SEC_PATH: begin
                if (in_byte_reg == CH_SPACE || in_byte_reg == CH_QUERY) begin
                    if (dphase_reg != DEC_PLAIN) begin
                        emit   = 1'b1;
                        emit_c = 8'd0;
                    end
                    dphase_next  = DEC_PLAIN;
                    hex_next     = 8'd0;
                    hcnt_next    = 2'd0;
                    section_next = (in_byte_reg == CH_SPACE) ? SEC_TAIL : SEC_QUERY;
                end else if (dphase_reg != DEC_PLAIN) begin
                    if (!hd[4]) begin
                        dphase_next = DEC_BAD;
                    end else if (dphase_reg == DEC_HEX) begin
                        hex_next = {hex_reg[3:0], hd[3:0]};
                    end
                    hcnt_next = hcnt_reg + 2'd1;
                    if (hcnt_next == 2'd2) begin
                        emit        = 1'b1;
                        emit_c      = (dphase_next == DEC_HEX) ? hex_next : 8'd0;
                        dphase_next = DEC_PLAIN;
                        hex_next    = 8'd0;
                        hcnt_next   = 2'd0;
                    end
                end else if (in_byte_reg == CH_PCT) begin
                    dphase_next = DEC_HEX;
                    hex_next    = 8'd0;
                    hcnt_next   = 2'd0;
                end else begin
                    emit   = 1'b1;
                    emit_c = in_byte_reg;
                end
            end
            SEC_QUERY: begin
                if (in_byte_reg == CH_SPACE) begin
                    section_next = SEC_TAIL;
                end
            end
            SEC_TAIL: begin
                if (in_byte_reg == CH_SPACE) begin
                    extra_next = 1'b1;
                end
            end
            default: ;
        endcase

        // cut escape at line end
        if (in_end_reg && section_next == SEC_PATH && dphase_next != DEC_PLAIN) begin
            emit        = 1'b1;
            emit_c      = 8'd0;
            dphase_next = DEC_PLAIN;
            hex_next    = 8'd0;
            hcnt_next   = 2'd0;
        end

        if (emit) begin
            // "/.." lowers the depth, any other slash raises it
            if (dotdot_reg == DD_DOT && emit_c == CH_DOT) begin
                if (depth_reg == '0) begin
                    forbid_next = 1'b1;
                end else begin
                    depth_next = depth_reg - 1'b1;
                end
                dotdot_next = DD_NONE;
            end else if (dotdot_reg == DD_SLASH && emit_c == CH_DOT) begin
                dotdot_next = DD_DOT;
            end else begin
                if (dotdot_reg != DD_NONE && depth_reg != '1) begin
                    depth_next = depth_reg + 1'b1;
                end
                dotdot_next = (emit_c == CH_SLASH) ? DD_SLASH : DD_NONE;
            end

            if (emit_c == CH_DOT) begin
                elen_next = 3'd1;
                ext_next  = 32'd0;
            end else if (elen_reg >= 3'd1 && elen_reg <= 3'd4) begin
                ext_next  = {ext_reg[23:0], emit_c};
                elen_next = elen_reg + 3'd1;
            end else if (elen_reg == 3'd5) begin
                elen_next = 3'd6;
            end
            lastc_next = emit_c;
            empty_next = 1'b0;
        end

        // verdict from the updated line state
        is_idx = empty_next || lastc_next == CH_SLASH;
        if (is_idx) begin
            ctype = CT_HTML;
        end else if (elen_next >= 3'd1 && elen_next <= 3'd5) begin
            ctype = ext_type(elen_next - 3'd1, ext_next);
        end else begin
            ctype = CT_UNKNOWN;
        end
        if (!mfail_next && method_next == M_GET) begin
            mclass = MC_GET;
        end else if (!mfail_next && method_next == M_HEAD) begin
            mclass = MC_HEAD;
        end else begin
            mclass = MC_OTHER;
        end
        ver = extra_next ? VER_BAD_REQ : (forbid_next ? VER_FORBIDDEN : VER_OK);
    end

    always_comb begin
        push.path_valid                = in_valid_reg && emit;
        push.path_item.item_kind       = KIND_PATH;
        push.path_item.path_byte       = emit_c;
        push.path_item.verdict         = VER_OK;
        push.path_item.method_class    = MC_GET;
        push.path_item.content_type    = CT_HTML;
        push.path_item.is_index        = 1'b0;
        push.path_item.last            = 1'b0;
        push.verdict_valid             = in_valid_reg && in_end_reg;
        push.verdict_item.item_kind    = KIND_VERDICT;
        push.verdict_item.path_byte    = 8'd0;
        push.verdict_item.verdict      = ver;
        push.verdict_item.method_class = mclass;
        push.verdict_item.content_type = ctype;
        push.verdict_item.is_index     = is_idx;
        push.verdict_item.last         = 1'b1;
    end

    assign busy = in_valid_reg;

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_byte_reg <= in_byte;
            in_end_reg  <= in_line_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (in_valid_reg && in_end_reg)) begin
            section_reg <= SEC_METHOD;
            method_reg  <= M_START;
            mfail_reg   <= 1'b0;
            extra_reg   <= 1'b0;
            dphase_reg  <= DEC_PLAIN;
            hex_reg     <= 8'd0;
            hcnt_reg    <= 2'd0;
            dotdot_reg  <= DD_NONE;
            depth_reg   <= '0;
            forbid_reg  <= 1'b0;
            ext_reg     <= 32'd0;
            elen_reg    <= 3'd0;
            lastc_reg   <= 8'd0;
            empty_reg   <= 1'b1;
        end else if (in_valid_reg) begin
            section_reg <= section_next;
            method_reg  <= method_next;
            mfail_reg   <= mfail_next;
            extra_reg   <= extra_next;
            dphase_reg  <= dphase_next;
            hex_reg     <= hex_next;
            hcnt_reg    <= hcnt_next;
            dotdot_reg  <= dotdot_next;
            depth_reg   <= depth_next;
            forbid_reg  <= forbid_next;
            ext_reg     <= ext_next;
            elen_reg    <= elen_next;
            lastc_reg   <= lastc_next;
            empty_reg   <= empty_next;
        end
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_accept;
        end
    end

endmodule

`default_nettype wire

/* rtl/hrlc_out_fifo.sv */
// hrlc_out_fifo: small result queue taking up to two results a cycle and
// delivering one while out_ready is high. Depends on hrlc_pkg.
`default_nettype none

module hrlc_out_fifo (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire hrlc_pkg::push_t       push,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output hrlc_pkg::item_t            out_item,
    output logic [hrlc_pkg::CNT_W-1:0] count
);
    import hrlc_pkg::*;

    item_t              mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_reg;
    logic [FIFO_AW-1:0] rd_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [1:0]         n_push;
    item_t              first, second;
    logic               pop;

    always_comb begin
        n_push = 2'(push.path_valid) + 2'(push.verdict_valid);
        first  = push.path_valid ? push.path_item : push.verdict_item;
        second = push.verdict_item;
    end

    assign out_valid  = count_reg != '0;
    assign out_item   = mem[rd_reg];
    assign pop        = out_valid && out_ready;
    assign count      = count_reg;
    assign count_next = count_reg + CNT_W'(n_push) - CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            mem[wr_reg] <= first;
        end
        if (n_push == 2'd2) begin
            mem[wr_reg + FIFO_AW'(1)] <= second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_reg + FIFO_AW'(n_push);
            rd_reg    <= rd_reg + FIFO_AW'(pop);
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/hrlc_checker.sv */
// hrlc_checker: port level checks for the request line checker, bound to
// http_request_line_checker_top. No package dependency.
`default_nettype none

module hrlc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [0:0]  m_tuser,
    input wire logic        m_tlast
);

    // reset leaves nothing queued and the input open
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("result pending or input closed after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // only the verdict closes a line
    a_last_is_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tlast == m_tuser[0])
        else $error("last flag and kind disagree");

    a_verdict_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[7:0] == 8'd0 && m_tdata[9:8] != 2'd3
                                   && m_tdata[11:10] != 2'd3)
        else $error("malformed verdict");

    a_path_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[23:8] == 16'd0)
        else $error("path byte carries verdict fields");

endmodule

bind http_request_line_checker_top hrlc_checker u_hrlc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

/* bench/tb_http_request_line_checker_top.sv */
// tb_http_request_line_checker_top: self-checking bench for the request line checker.
// Depends on hrlc_pkg and http_request_line_checker_top; predicts decoded path bytes
// and line verdicts in its own model and checks every result in order.

module tb_http_request_line_checker_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hrlc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int          MAX_REPORTS = 10;

    typedef enum logic [1:0] {SEC_METHOD, SEC_PATH, SEC_QUERY, SEC_AFTER} section_t;
    typedef enum logic [1:0] {ESC_NONE, ESC_HEX, ESC_BAD} escape_t;
    typedef enum logic [1:0] {DOTS_NONE, DOTS_SLASH, DOTS_SLASH_DOT} dots_t;
    typedef enum logic [2:0] {M_START, M_G, M_GE, M_GET, M_H, M_HE, M_HEA, M_HEAD} method_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    // line parsing state of the prediction
    section_t                sec;
    method_t                 mth;
    logic                    mth_bad;
    logic                    third_space;
    escape_t                 esc;
    logic [7:0]              hex_acc;
    logic [1:0]              hex_cnt;
    dots_t                   dots;
    logic [DEPTH_BITS-1:0]   depth;
    logic                    climbed_out;
    logic [31:0]             ext_word;
    logic [2:0]              ext_cnt;
    logic [7:0]              last_char;
    logic                    path_seen;

    item_t       line_results_due[$];
    logic [7:0]  line_buf[$];
    int          bytes_sent = 0;
    int          mismatch_count = 0;
    int unsigned cycle_count = 0;
    int          src_idle_pct = 0;
    int          sink_idle_pct = 0;

    string ext_names[11] = '{"html", "css", "js", "jpg", "jpeg", "png", "gif", "swf",
                             "HTML", "jpegx", ""};

    http_request_line_checker_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    function automatic void reset_line();
        sec = SEC_METHOD;
        mth = M_START;
        mth_bad = 1'b0;
        third_space = 1'b0;
        esc = ESC_NONE;
        hex_acc = '0;
        hex_cnt = '0;
        dots = DOTS_NONE;
        depth = '0;
        climbed_out = 1'b0;
        ext_word = '0;
        ext_cnt = '0;
        last_char = '0;
        path_seen = 1'b0;
    endfunction

    // one decoded path byte: traversal scan, extension tracking, result
    function automatic void emit_decoded(input logic [7:0] c);
        item_t r;
        if (dots == DOTS_SLASH_DOT && c == CH_DOT) begin
            if (depth == '0) climbed_out = 1'b1;
            else depth = depth - 1'b1;
            dots = DOTS_NONE;
        end else if (dots == DOTS_SLASH && c == CH_DOT) begin
            dots = DOTS_SLASH_DOT;
        end else begin
            // saturating climb
            if (dots != DOTS_NONE && depth != '1) depth = depth + 1'b1;
            dots = (c == CH_SLASH) ? DOTS_SLASH : DOTS_NONE;
        end
        if (c == CH_DOT) begin
            ext_cnt = 3'd1;
            ext_word = '0;
        end else if (ext_cnt >= 3'd1 && ext_cnt <= 3'd4) begin
            ext_word = {ext_word[23:0], c};
            ext_cnt = ext_cnt + 3'd1;
        end else if (ext_cnt == 3'd5) begin
            ext_cnt = 3'd6;
        end
        last_char = c;
        path_seen = 1'b1;
        r = '0;
        r.item_kind = KIND_PATH;
        r.path_byte = c;
        line_results_due.push_back(r);
    endfunction

    // an escape cut short decodes to zero
    function automatic void flush_escape();
        if (esc != ESC_NONE) begin
            emit_decoded(8'h00);
            esc = ESC_NONE;
            hex_acc = '0;
            hex_cnt = '0;
        end
    endfunction

    function automatic void parse_request_byte(input logic [7:0] c, input logic eol);
        logic [4:0] nib;
        logic [3:0] ct;
        item_t      v;
        case (sec)
            SEC_METHOD: begin
                if (c == CH_SPACE) begin
                    sec = SEC_PATH;
                end else if (!mth_bad) begin
                    case (mth)
                        M_START: begin
                            if (c == CH_G) mth = M_G;
                            else if (c == CH_H) mth = M_H;
                            else mth_bad = 1'b1;
                        end
                        M_G:   if (c == CH_E) mth = M_GE;  else mth_bad = 1'b1;
                        M_GE:  if (c == CH_T) mth = M_GET; else mth_bad = 1'b1;
                        M_H:   if (c == CH_E) mth = M_HE;  else mth_bad = 1'b1;
                        M_HE:  if (c == CH_A) mth = M_HEA; else mth_bad = 1'b1;
                        M_HEA: if (c == CH_D) mth = M_HEAD; else mth_bad = 1'b1;
                        default: mth_bad = 1'b1;
                    endcase
                end
            end
            SEC_PATH: begin
                if (c == CH_SPACE || c == CH_QUERY) begin
                    flush_escape();
                    sec = (c == CH_SPACE) ? SEC_AFTER : SEC_QUERY;
                end else if (esc != ESC_NONE) begin
                    if (c >= "0" && c <= "9") nib = {1'b1, 4'(c - "0")};
                    else if (c >= "a" && c <= "f") nib = {1'b1, 4'(c - "a" + 8'd10)};
                    else if (c >= "A" && c <= "F") nib = {1'b1, 4'(c - "A" + 8'd10)};
                    else nib = '0;
                    if (!nib[4]) esc = ESC_BAD;
                    else if (esc == ESC_HEX) hex_acc = {hex_acc[3:0], nib[3:0]};
                    hex_cnt = hex_cnt + 2'd1;
                    if (hex_cnt >= 2'd2) begin
                        emit_decoded(esc == ESC_HEX ? hex_acc : 8'h00);
                        esc = ESC_NONE;
                        hex_acc = '0;
                        hex_cnt = '0;
                    end
                end else if (c == CH_PCT) begin
                    esc = ESC_HEX;
                    hex_acc = '0;
                    hex_cnt = '0;
                end else begin
                    emit_decoded(c);
                end
            end
            SEC_QUERY: if (c == CH_SPACE) sec = SEC_AFTER;
            default:   if (c == CH_SPACE) third_space = 1'b1;
        endcase

        if (eol) begin
            if (sec == SEC_PATH) flush_escape();
            v = '0;
            v.item_kind = KIND_VERDICT;
            v.last = 1'b1;
            v.verdict = third_space ? VER_BAD_REQ : (climbed_out ? VER_FORBIDDEN : VER_OK);
            if (!mth_bad && mth == M_GET) v.method_class = MC_GET;
            else if (!mth_bad && mth == M_HEAD) v.method_class = MC_HEAD;
            else v.method_class = MC_OTHER;
            v.is_index = !path_seen || last_char == CH_SLASH;
            ct = CT_UNKNOWN;
            // ext_cnt counts the dot too
            case (ext_cnt)
                3'd5: begin
                    if (ext_word == "html") ct = CT_HTML;
                    else if (ext_word == "jpeg") ct = CT_JPEG;
                end
                3'd4: begin
                    if (ext_word == "css") ct = CT_CSS;
                    else if (ext_word == "jpg") ct = CT_JPG;
                    else if (ext_word == "png") ct = CT_PNG;
                    else if (ext_word == "gif") ct = CT_GIF;
                    else if (ext_word == "swf") ct = CT_SWF;
                end
                3'd3: if (ext_word == "js") ct = CT_JS;
                default: ;
            endcase
            v.content_type = v.is_index ? CT_HTML : ct;
            line_results_due.push_back(v);
            reset_line();
        end
    endfunction

    function automatic void report_mismatch(input string what, input item_t want,
                                            input item_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%s: expected kind=%0d byte=%02h ver=%0d mc=%0d ct=%0d idx=%0d last=%0d",
                     what, want.item_kind, want.path_byte, want.verdict, want.method_class,
                     want.content_type, want.is_index, want.last);
            $display("    got kind=%0d byte=%02h ver=%0d mc=%0d ct=%0d idx=%0d last=%0d",
                     got.item_kind, got.path_byte, got.verdict, got.method_class,
                     got.content_type, got.is_index, got.last);
        end
    endfunction

    always @(posedge aclk) begin : result_check
        item_t got;
        item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.item_kind    = m_tuser[0];
            got.path_byte    = m_tdata[7:0];
            got.verdict      = m_tdata[9:8];
            got.method_class = m_tdata[11:10];
            got.content_type = m_tdata[15:12];
            got.is_index     = m_tdata[16];
            got.last         = m_tlast;
            if (line_results_due.size() == 0) begin
                report_mismatch("result with none pending", '0, got);
            end else begin
                want = line_results_due.pop_front();
                if (got !== want) report_mismatch("result mismatch", want, got);
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_request(input logic [7:0] b, input logic eol);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eol;
        do @(posedge aclk); while (!s_tready);
        parse_request_byte(b, eol);
        bytes_sent++;
        @(negedge aclk);
    endtask

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endfunction

    task automatic send_line_buf();
        for (int i = 0; i < line_buf.size(); i++) send_request(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
    endtask

    task automatic send_line(input string s);
        put_text(s);
        send_line_buf();
    endtask

    // sender holds off until the result queue is empty
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (line_results_due.size() != 0) @(negedge aclk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] h;
        h = (n < 4'd10) ? "0" + 8'(n) : "a" + 8'(n) - 8'd10;
        if (h >= "a" && $urandom_range(1) == 1) h = h - 8'h20;
        return h;
    endfunction

    task automatic test_methods();
        send_line("GET /");
        send_line("HEAD /x.png HTTP/1.0");
        send_line("GETS /a.gif");
        send_line("G");
    endtask

    task automatic test_field_extremes();
        line_buf.push_back(8'hFF);
        put_text(" /");
        line_buf.push_back(8'h00);
        line_buf.push_back(8'hFF);
        send_line_buf();
        // a line of one space: empty method, empty path
        send_line(" ");
    endtask

    task automatic test_percent_escapes();
        send_line("GET /%41%2F%7e%zz%G1 x");
        send_line("GET /a%4?q=1");
        send_line("GET /b%4 HTTP");
        send_line("GET /c%");
        send_line("GET /%ff%00");
    endtask

    task automatic test_traversal();
        send_line("GET /a/b/../c.css");
        send_line("GET /a/../../etc");
        send_line("GET /%2e%2e/x");
        // extra space outranks forbidden
        send_line("GET /../x HTTP/1.1 extra");
    endtask

    task automatic test_missing_spaces();
        send_line("HEAD");
        send_line("GET /dir/");
        send_line("GET /a.js?x=1.png");
    endtask

    task automatic test_extensions();
        foreach (ext_names[i]) send_line({"GET /f.", ext_names[i]});
    endtask

    // exactly 2^DEPTH_BITS climbs: a wrapping counter would hit zero and the
    // closing ".." would flag the line forbidden
    task automatic test_depth_saturation();
        put_text("GET ");
        repeat ((1 << DEPTH_BITS) + 1) line_buf.push_back(CH_SLASH);
        put_text("..");
        send_line_buf();
    endtask

    task automatic test_random_lines(input int n_bytes);
        int         stop_at;
        bit         cut;
        logic [7:0] b;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(99) < 10) begin
                // noise
                repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom));
            end else begin
                case ($urandom_range(7))
                    0, 1: put_text("GET");
                    2, 3: put_text("HEAD");
                    4:    put_text("POST");
                    5:    put_text("GE");
                    6:    put_text("HEADS");
                    default: repeat ($urandom_range(3))
                        line_buf.push_back(8'($urandom_range(8'h41, 8'h5A)));
                endcase
                if ($urandom_range(19) != 0) begin
                    line_buf.push_back(CH_SPACE);
                    cut = 1'b0;
                    repeat ($urandom_range(5)) begin
                        if (!cut) begin
                            case ($urandom_range(9))
                                0: put_text("/");
                                1: put_text("/..");
                                2: put_text("/.");
                                3: begin
                                    put_text("/");
                                    repeat ($urandom_range(1, 4))
                                        line_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
                                end
                                4: put_text({".", ext_names[$urandom_range(10)]});
                                5: begin
                                    if ($urandom_range(2) == 0) b = 8'($urandom);
                                    else b = $urandom_range(1) ? CH_SLASH : CH_DOT;
                                    line_buf.push_back(CH_PCT);
                                    line_buf.push_back(hex_char(b[7:4]));
                                    line_buf.push_back(hex_char(b[3:0]));
                                end
                                6: begin
                                    line_buf.push_back(CH_PCT);
                                    line_buf.push_back(8'($urandom));
                                    line_buf.push_back(8'($urandom));
                                end
                                7: begin
                                    // escape left open by the end of the line
                                    line_buf.push_back(CH_PCT);
                                    if ($urandom_range(1)) line_buf.push_back(hex_char(4'($urandom)));
                                    cut = 1'b1;
                                end
                                default: line_buf.push_back(8'($urandom));
                            endcase
                        end
                    end
                    if (!cut) begin
                        if ($urandom_range(3) == 0) begin
                            put_text("?");
                            repeat ($urandom_range(4)) line_buf.push_back(8'($urandom));
                        end
                        if ($urandom_range(1)) put_text(" HTTP/1.1");
                        if ($urandom_range(9) == 0) put_text(" x");
                    end
                end
            end
            if (line_buf.size() == 0) line_buf.push_back(8'($urandom));
            send_line_buf();
        end
    endtask

    initial begin
        reset_line();
        src_idle_pct = 31;
        sink_idle_pct = 63;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_methods();
        test_field_extremes();
        test_percent_escapes();
        test_traversal();
        test_missing_spaces();
        test_extensions();
        test_depth_saturation();

        test_random_lines(150);
        wait_results_drained();
        src_idle_pct = 63;
        sink_idle_pct = 31;
        test_random_lines(150);
        wait_results_drained();
        src_idle_pct = 0;
        sink_idle_pct = 0;
        test_random_lines(150);

        wait_results_drained();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
